// ----- rtl/core/pfsa_pkg.sv -----
// Shared types and constants for the page frame stack allocator.
package pfsa_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int PAGE_BITS   = 44;
  localparam int REM_W       = PAGE_BITS + 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CFG_IDX_W   = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_PAGE = 1'b0,
    REG_END_PAGE   = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_FREE = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    req_kind_t              kind;
    logic [PAGE_BITS-1:0]   page_number;
  } in_beat_t;

  typedef struct packed {
    logic [PAGE_BITS-1:0]   page_out;
    status_t                status;
    logic [REM_W-1:0]       remaining;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP,
    S_SCAN,
    S_REPORT
  } pfsa_state_t;

  typedef struct packed {
    logic    latch_req;
    logic    pop_rd;
    logic    pop_take;
    logic    bump;
    logic    scan_start;
    logic    scan_run;
    logic    push;
    logic    fail;
    status_t fail_status;
    logic    load_out;
  } pfsa_cmd_t;

  typedef struct packed {
    logic is_free;
    logic stack_empty;
    logic bump_ok;
    logic victim_ok;
    logic scan_done;
    logic scan_hit;
    logic stack_full;
    logic out_busy;
  } pfsa_sts_t;

endpackage

// ----- rtl/core/page_frame_stack_allocator.sv -----
// Top level of the page frame stack allocator: sequencer plus datapath.
// Throughput: one request at a time. A free of a page at or above the bump pointer is rejected
// early; any other free scans the recycle stack for a duplicate through its single read
// port, one entry per cycle, before the push.
// Reset (synchronous, rst_n low): clears the sequencer state, end page, bump pointer, stack count,
// scan state and output valid; stack contents and data registers stay and need no clearing pass.
module page_frame_stack_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pfsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfsa_pkg::PAGE_BITS-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pfsa_pkg::in_beat_t             in_beat,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pfsa_pkg::out_beat_t            out_beat
);

  pfsa_pkg::pfsa_cmd_t cmd;
  pfsa_pkg::pfsa_sts_t sts;

  pfsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfsa_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- rtl/core/pfsa_ctrl.sv -----
// Request sequencer for the page frame stack allocator.
module pfsa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pfsa_pkg::pfsa_sts_t sts,
  output pfsa_pkg::pfsa_cmd_t cmd
);

  pfsa_pkg::pfsa_state_t state_r;
  pfsa_pkg::pfsa_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfsa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfsa_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = pfsa_pkg::S_DISPATCH;
        end
      end
      pfsa_pkg::S_DISPATCH: begin
        if (!sts.is_free) begin
          state_nxt = sts.stack_empty ? pfsa_pkg::S_REPORT : pfsa_pkg::S_POP;
        end else begin
          state_nxt = sts.victim_ok ? pfsa_pkg::S_SCAN : pfsa_pkg::S_REPORT;
        end
      end
      pfsa_pkg::S_POP: begin
        state_nxt = pfsa_pkg::S_REPORT;
      end
      pfsa_pkg::S_SCAN: begin
        if (sts.scan_hit || sts.scan_done) begin
          state_nxt = pfsa_pkg::S_REPORT;
        end
      end
      pfsa_pkg::S_REPORT: begin
        if (!sts.out_busy) begin
          state_nxt = pfsa_pkg::S_IDLE;
        end
      end
      default: state_nxt = pfsa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.fail_status = pfsa_pkg::ST_OK;
    in_ready = 1'b0;
    case (state_r)
      pfsa_pkg::S_IDLE: begin
        in_ready      = 1'b1;
        cmd.latch_req = in_valid;
      end
      pfsa_pkg::S_DISPATCH: begin
        if (!sts.is_free) begin
          if (!sts.stack_empty) begin
            cmd.pop_rd = 1'b1;
          end else if (sts.bump_ok) begin
            cmd.bump = 1'b1;
          end else begin
            cmd.fail        = 1'b1;
            cmd.fail_status = pfsa_pkg::ST_EMPTY;
          end
        end else if (sts.victim_ok) begin
          cmd.scan_start = 1'b1;
        end else begin
          cmd.fail        = 1'b1;
          cmd.fail_status = pfsa_pkg::ST_BAD_FREE;
        end
      end
      pfsa_pkg::S_POP: begin
        cmd.pop_take = 1'b1;
      end
      pfsa_pkg::S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_hit) begin
          cmd.fail        = 1'b1;
          cmd.fail_status = pfsa_pkg::ST_BAD_FREE;
        end else if (sts.scan_done) begin
          if (sts.stack_full) begin
            cmd.fail        = 1'b1;
            cmd.fail_status = pfsa_pkg::ST_FULL;
          end else begin
            cmd.push = 1'b1;
          end
        end
      end
      pfsa_pkg::S_REPORT: begin
        cmd.load_out = !sts.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/core/pfsa_dpath.sv -----
// Datapath for the page frame stack allocator: registers, recycle stack and output stage.
module pfsa_dpath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pfsa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pfsa_pkg::PAGE_BITS-1:0]       cfg_wdata,
  input  pfsa_pkg::in_beat_t                   in_beat,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output pfsa_pkg::out_beat_t                  out_beat,
  input  pfsa_pkg::pfsa_cmd_t                  cmd,
  output pfsa_pkg::pfsa_sts_t                  sts
);

  localparam int PB = pfsa_pkg::PAGE_BITS;
  localparam int CW = pfsa_pkg::CNT_W;
  localparam int AW = pfsa_pkg::ADDR_W;
  localparam int RW = pfsa_pkg::REM_W;

  logic [PB-1:0] mem [pfsa_pkg::STACK_DEPTH];

  logic [PB-1:0]       end_page_r;
  logic [PB-1:0]       next_page_r;
  logic [CW-1:0]       count_r;
  pfsa_pkg::req_kind_t req_kind_r;
  logic [PB-1:0]       req_page_r;
  logic [PB-1:0]       rdata_r;
  logic [CW-1:0]       scan_idx_r;
  logic                cmp_valid_r;
  logic                hit_r;
  logic [PB-1:0]       res_page_r;
  pfsa_pkg::status_t   res_status_r;
  logic                out_valid_r;
  pfsa_pkg::out_beat_t out_beat_r;

  logic [CW-1:0] pop_idx;
  logic          scan_rd;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [RW-1:0] bump_left;
  logic [RW-1:0] remaining;

  assign pop_idx = count_r - CW'(1);
  assign scan_rd = cmd.scan_run && (scan_idx_r < count_r);
  assign rd_en   = cmd.pop_rd || scan_rd;
  assign rd_addr = cmd.pop_rd ? pop_idx[AW-1:0] : scan_idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[count_r[AW-1:0]] <= req_page_r;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_page_r  <= '0;
      next_page_r <= '0;
      count_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (pfsa_pkg::cfg_reg_t'(cfg_index))
          pfsa_pkg::REG_START_PAGE: begin
            next_page_r <= cfg_wdata;
            count_r     <= '0;
          end
          pfsa_pkg::REG_END_PAGE: begin
            end_page_r <= cfg_wdata;
          end
          default: begin
            end_page_r <= end_page_r;
          end
        endcase
      end
      if (cmd.bump) begin
        next_page_r <= next_page_r + PB'(1);
      end
      if (cmd.pop_take) begin
        count_r <= pop_idx;
      end
      if (cmd.push) begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_kind_r <= in_beat.kind;
      req_page_r <= in_beat.page_number;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r  <= '0;
      cmp_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_idx_r  <= '0;
      cmp_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else if (cmd.scan_run) begin
      cmp_valid_r <= scan_rd;
      if (scan_rd) begin
        scan_idx_r <= scan_idx_r + CW'(1);
      end
      if (cmp_valid_r && (rdata_r == req_page_r)) begin
        hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bump) begin
      res_page_r   <= next_page_r;
      res_status_r <= pfsa_pkg::ST_OK;
    end else if (cmd.pop_take) begin
      res_page_r   <= rdata_r;
      res_status_r <= pfsa_pkg::ST_OK;
    end else if (cmd.push) begin
      res_page_r   <= '0;
      res_status_r <= pfsa_pkg::ST_OK;
    end else if (cmd.fail) begin
      res_page_r   <= '0;
      res_status_r <= cmd.fail_status;
    end
  end

  assign bump_left = (end_page_r > next_page_r) ? {1'b0, end_page_r - next_page_r} : '0;
  assign remaining = bump_left + RW'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_beat_r.page_out  <= res_page_r;
      out_beat_r.status    <= res_status_r;
      out_beat_r.remaining <= remaining;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  assign sts.is_free     = (req_kind_r == pfsa_pkg::KIND_FREE);
  assign sts.stack_empty = (count_r == '0);
  assign sts.bump_ok     = (next_page_r < end_page_r);
  assign sts.victim_ok   = (req_page_r < next_page_r);
  assign sts.scan_done   = (scan_idx_r == count_r) && !cmp_valid_r;
  assign sts.scan_hit    = hit_r;
  assign sts.stack_full  = (count_r == CW'(pfsa_pkg::STACK_DEPTH));
  assign sts.out_busy    = out_valid_r && !out_ready;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(pfsa_pkg::STACK_DEPTH))
    else $error("stack count past depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (count_r < CW'(pfsa_pkg::STACK_DEPTH)) && !hit_r)
    else $error("push into full stack or after duplicate hit");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_take |-> (count_r != '0) && $past(cmd.pop_rd))
    else $error("pop without issued read");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && !out_ready))
    else $error("result overwrote waiting beat");

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for the page frame stack allocator: directed and random requests vs a predictor.
module tb_top;

  typedef logic [pfsa_pkg::PAGE_BITS-1:0] page_t;

  localparam page_t PAGE_MAX = '1;
  localparam int unsigned CFG_CHUNK = 48;

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [pfsa_pkg::CFG_IDX_W-1:0] cfg_index = pfsa_pkg::REG_START_PAGE;
  page_t                          cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  pfsa_pkg::in_beat_t             in_beat = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  pfsa_pkg::out_beat_t            out_beat;

  page_frame_stack_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  // allocator shadow state
  page_t                alloc_start = '0;
  page_t                alloc_end = '0;
  page_t                bump_ptr = '0;
  page_t                recycled [pfsa_pkg::STACK_DEPTH];
  int unsigned          recycled_cnt = 0;

  pfsa_pkg::out_beat_t  expected_frames [$];
  page_t                held_pages [$];
  int unsigned          mismatch_count = 0;
  int unsigned          send_idle_pct = 0;
  int unsigned          recv_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("[page_frame_stack_allocator] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic page_t rand_page();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[pfsa_pkg::PAGE_BITS-1:0];
  endfunction

  function automatic pfsa_pkg::out_beat_t predict_frame_result(input pfsa_pkg::in_beat_t req);
    pfsa_pkg::out_beat_t        res;
    logic [pfsa_pkg::REM_W-1:0] bump_left;
    bit                         dup;
    int unsigned                i;
    res = '0;
    res.status = pfsa_pkg::ST_OK;
    if (req.kind == pfsa_pkg::KIND_ALLOC) begin
      if (recycled_cnt > 0) begin
        recycled_cnt--;
        res.page_out = recycled[recycled_cnt];
      end else if (bump_ptr < alloc_end) begin
        res.page_out = bump_ptr;
        bump_ptr = bump_ptr + 1'b1;
      end else begin
        res.status = pfsa_pkg::ST_EMPTY;
      end
    end else begin
      dup = 1'b0;
      for (i = 0; i < recycled_cnt; i++) begin
        if (recycled[i] == req.page_number) dup = 1'b1;
      end
      if (req.page_number >= bump_ptr || dup) begin
        res.status = pfsa_pkg::ST_BAD_FREE;
      end else if (recycled_cnt >= pfsa_pkg::STACK_DEPTH) begin
        res.status = pfsa_pkg::ST_FULL;
      end else begin
        recycled[recycled_cnt] = req.page_number;
        recycled_cnt++;
      end
    end
    bump_left = (alloc_end > bump_ptr) ? pfsa_pkg::REM_W'(alloc_end - bump_ptr) : '0;
    res.remaining = bump_left + pfsa_pkg::REM_W'(recycled_cnt);
    return res;
  endfunction

  always @(posedge clk) begin
    pfsa_pkg::out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        $error("unexpected result beat: page_out %h status %0d remaining %h",
               out_beat.page_out, out_beat.status, out_beat.remaining);
        mismatch_count++;
      end else begin
        want = expected_frames.pop_front();
        if (out_beat.page_out !== want.page_out) begin
          $error("page_out: expected %h, got %h", want.page_out, out_beat.page_out);
          mismatch_count++;
        end
        if (out_beat.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_beat.status);
          mismatch_count++;
        end
        if (out_beat.remaining !== want.remaining) begin
          $error("remaining: expected %h, got %h", want.remaining, out_beat.remaining);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_request(input pfsa_pkg::req_kind_t kind, input page_t page,
                              output pfsa_pkg::out_beat_t pred);
    pfsa_pkg::in_beat_t req;
    req.kind = kind;
    req.page_number = page;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = predict_frame_result(req);
    expected_frames.push_back(pred);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input pfsa_pkg::cfg_reg_t idx, input page_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == pfsa_pkg::REG_START_PAGE) begin
      alloc_start  = value;
      bump_ptr     = value;
      recycled_cnt = 0;
      held_pages.delete();
    end else begin
      alloc_end = value;
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure_allocator(input page_t first, input page_t last);
    wait_idle();
    write_reg(pfsa_pkg::REG_START_PAGE, first);
    write_reg(pfsa_pkg::REG_END_PAGE, last);
  endtask

  task automatic reconfigure_random();
    page_t       first;
    page_t       last;
    int unsigned span;
    span  = $urandom_range(1, 40);
    first = rand_page();
    case ($urandom_range(4))
      0: begin
        last = (first > PAGE_MAX - page_t'(span)) ? PAGE_MAX : first + page_t'(span);
      end
      1: begin
        first = '0;
        last  = PAGE_MAX;
      end
      2: begin
        first = PAGE_MAX - page_t'(span);
        last  = PAGE_MAX;
      end
      3: begin
        last = (first > page_t'(3)) ? first - page_t'($urandom_range(0, 3)) : '0;
      end
      default: begin
        first = PAGE_MAX;
        last  = PAGE_MAX;
      end
    endcase
    configure_allocator(first, last);
  endtask

  task automatic test_reset_values();
    pfsa_pkg::out_beat_t pred;
    send_request(pfsa_pkg::KIND_ALLOC, rand_page(), pred);
    send_request(pfsa_pkg::KIND_FREE, '0, pred);
  endtask

  task automatic test_basic_recycle();
    pfsa_pkg::out_beat_t pred;
    configure_allocator(44'd100, 44'd103);
    send_request(pfsa_pkg::KIND_ALLOC, '0, pred);
    send_request(pfsa_pkg::KIND_ALLOC, PAGE_MAX, pred);
    send_request(pfsa_pkg::KIND_FREE, 44'd101, pred);
    send_request(pfsa_pkg::KIND_FREE, 44'd101, pred);
    send_request(pfsa_pkg::KIND_FREE, 44'd200, pred);
    send_request(pfsa_pkg::KIND_FREE, 44'd102, pred);
    send_request(pfsa_pkg::KIND_FREE, 44'd0, pred);
    send_request(pfsa_pkg::KIND_ALLOC, rand_page(), pred);
    send_request(pfsa_pkg::KIND_ALLOC, rand_page(), pred);
    send_request(pfsa_pkg::KIND_ALLOC, rand_page(), pred);
    send_request(pfsa_pkg::KIND_ALLOC, rand_page(), pred);
    send_request(pfsa_pkg::KIND_FREE, 44'd100, pred);
    send_request(pfsa_pkg::KIND_ALLOC, rand_page(), pred);
  endtask

  task automatic test_top_of_range();
    pfsa_pkg::out_beat_t pred;
    configure_allocator(PAGE_MAX - page_t'(2), PAGE_MAX);
    send_request(pfsa_pkg::KIND_ALLOC, rand_page(), pred);
    send_request(pfsa_pkg::KIND_ALLOC, rand_page(), pred);
    send_request(pfsa_pkg::KIND_ALLOC, rand_page(), pred);
    send_request(pfsa_pkg::KIND_FREE, PAGE_MAX - page_t'(1), pred);
    send_request(pfsa_pkg::KIND_FREE, PAGE_MAX, pred);
    send_request(pfsa_pkg::KIND_FREE, PAGE_MAX - page_t'(1), pred);
    send_request(pfsa_pkg::KIND_ALLOC, rand_page(), pred);
    wait_idle();
    write_reg(pfsa_pkg::REG_END_PAGE, 44'd5);
    send_request(pfsa_pkg::KIND_ALLOC, rand_page(), pred);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned         i;
    int unsigned         pick;
    int unsigned         roll;
    pfsa_pkg::req_kind_t kind;
    page_t               page;
    pfsa_pkg::out_beat_t pred;
    for (i = 0; i < count; i++) begin
      if (i % CFG_CHUNK == 0) begin
        reconfigure_random();
      end else if ($urandom_range(99) < 2) begin
        wait_idle();
        write_reg(pfsa_pkg::REG_END_PAGE,
                  bump_ptr - page_t'(2) + page_t'($urandom_range(0, 6)));
      end else if ($urandom_range(99) < 3) begin
        wait_idle();
      end
      kind = pfsa_pkg::KIND_FREE;
      page = rand_page();
      roll = $urandom_range(99);
      if (roll < 45) begin
        kind = pfsa_pkg::KIND_ALLOC;
      end else if (roll < 75 && held_pages.size() > 0) begin
        pick = $urandom_range(held_pages.size() - 1);
        page = held_pages[pick];
        held_pages.delete(pick);
      end else if (roll < 85 && recycled_cnt > 0) begin
        page = recycled[$urandom_range(recycled_cnt - 1)];
      end else if (roll < 93) begin
        page = bump_ptr - page_t'(1) + page_t'($urandom_range(0, 2));
      end
      send_request(kind, page, pred);
      if (kind == pfsa_pkg::KIND_ALLOC && pred.status == pfsa_pkg::ST_OK) begin
        held_pages.push_back(pred.page_out);
      end
    end
  endtask

  task automatic test_stack_full();
    int unsigned         i;
    page_t               base;
    pfsa_pkg::out_beat_t pred;
    base = page_t'(4 * pfsa_pkg::STACK_DEPTH);
    configure_allocator(base, base + page_t'(64));
    for (i = 0; i < pfsa_pkg::STACK_DEPTH; i++) begin
      send_request(pfsa_pkg::KIND_FREE, page_t'(i), pred);
    end
    send_request(pfsa_pkg::KIND_FREE, page_t'(pfsa_pkg::STACK_DEPTH), pred);
    send_request(pfsa_pkg::KIND_FREE, '0, pred);
    send_request(pfsa_pkg::KIND_ALLOC, rand_page(), pred);
    send_request(pfsa_pkg::KIND_FREE, page_t'(pfsa_pkg::STACK_DEPTH), pred);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 38;
    recv_idle_pct = 57;
    test_reset_values();
    test_basic_recycle();
    test_top_of_range();
    test_random_traffic(190);

    send_idle_pct = 57;
    recv_idle_pct = 38;
    test_random_traffic(190);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(200);
    test_stack_full();

    wait_idle();
    repeat (32) @(posedge clk);
    if (mismatch_count == 0 && expected_frames.size() == 0) begin
      $display("[page_frame_stack_allocator] OK");
    end else begin
      $display("[page_frame_stack_allocator] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/pfsa_pkg.sv
rtl/core/pfsa_ctrl.sv
rtl/core/pfsa_dpath.sv
rtl/core/page_frame_stack_allocator.sv
tb/sv/tb_top.sv
